[rtl/vts_pkg.sv]
// Shared types and constants of the trilinear volume sampler.
`default_nettype none
package vts_pkg;

    localparam int DIM_X_DEF = 64;
    localparam int DIM_Y_DEF = 64;
    localparam int DIM_Z_DEF = 64;

    localparam int COORD_W   = 32;
    localparam int VOX_W     = 16;
    localparam int OUT_W     = 40;
    localparam int FRAC_W    = 17;
    localparam int WGT_W     = 18;
    localparam int IDX_W     = 10;
    localparam int LOAD_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

    localparam logic [31:0] INV_RESET = 32'd65536;

    // One classified word passed from the front to the back.
    typedef struct packed {
        logic                     is_load;
        logic                     hit;
        logic [VOX_W-1:0]         voxel;
        logic [IDX_W-1:0]         ix;
        logic [IDX_W-1:0]         iy;
        logic [IDX_W-1:0]         iz;
        logic signed [FRAC_W-1:0] fx;
        logic signed [FRAC_W-1:0] fy;
        logic signed [FRAC_W-1:0] fz;
    } entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage
`default_nettype wire

[rtl/vts_item_if.sv]
// Input item channel of the sampler.
`default_nettype none
interface vts_item_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [vts_pkg::VOX_W-1:0]           voxel_value;
    logic signed [vts_pkg::COORD_W-1:0]  point_x;
    logic signed [vts_pkg::COORD_W-1:0]  point_y;
    logic signed [vts_pkg::COORD_W-1:0]  point_z;

    modport source (output valid, opcode, voxel_value, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, opcode, voxel_value, point_x, point_y, point_z,
                  output ready);
endinterface
`default_nettype wire

[rtl/vts_result_if.sv]
// Result channel of the sampler.
`default_nettype none
interface vts_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [vts_pkg::OUT_W-1:0]  sampled_value;
    logic                              inside_grid;

    modport source (output valid, sampled_value, inside_grid, input ready);
    modport sink (input valid, sampled_value, inside_grid, output ready);
endinterface
`default_nettype wire

[rtl/vts_cfg_if.sv]
// Configuration write channel of the sampler.
`default_nettype none
interface vts_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [vts_pkg::CFG_IDX_W-1:0]      index;
    logic [31:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/volume_trilinear_sampler.sv]
// Top level of the trilinear volume sampler.
// A query passes through the front one axis at a time (one shared 32x32 multiplier, a multiply
// state and a check state per axis); in the back, from the pop to a valid result, it takes 8 corner
// reads from the single-port voxel memory and then the blend pipeline; a new query starts in the back
// once the previous result is taken.
// A load passes through the front's intake and push states and is one memory write in the back; loads give no result.
// rst_n clears control state, the load position and the configuration registers at once;
// the voxel store is not cleared and holds undefined data until written.
`default_nettype none
module volume_trilinear_sampler #(
    parameter int DIM_X = vts_pkg::DIM_X_DEF,
    parameter int DIM_Y = vts_pkg::DIM_Y_DEF,
    parameter int DIM_Z = vts_pkg::DIM_Z_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    vts_item_if.sink      item,
    vts_cfg_if.sink       cfg,
    vts_result_if.source  result
);

    vts_pkg::entry_t   push_entry;
    vts_pkg::entry_t   head;
    vts_pkg::q_stat_t  q_stat;
    logic              push;
    logic              pop;

    vts_front #(
        .DIM_X (DIM_X),
        .DIM_Y (DIM_Y),
        .DIM_Z (DIM_Z)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .push_entry (push_entry),
        .push       (push),
        .q_stat     (q_stat)
    );

    vts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    vts_back #(
        .DIM_X (DIM_X),
        .DIM_Y (DIM_Y),
        .DIM_Z (DIM_Z)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

[rtl/vts_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module vts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule
`default_nettype wire

[rtl/vts_front.sv]
// Front end: configuration registers, item intake and per-axis cell classification.
`default_nettype none
module vts_front #(
    parameter int DIM_X = vts_pkg::DIM_X_DEF,
    parameter int DIM_Y = vts_pkg::DIM_Y_DEF,
    parameter int DIM_Z = vts_pkg::DIM_Z_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    vts_item_if.sink          item,
    vts_cfg_if.sink           cfg,
    output vts_pkg::entry_t   push_entry,
    output logic              push,
    input  vts_pkg::q_stat_t  q_stat
);

    localparam logic [31:0] LIM_X = 32'(DIM_X - 2);
    localparam logic [31:0] LIM_Y = 32'(DIM_Y - 2);
    localparam logic [31:0] LIM_Z = 32'(DIM_Z - 2);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_CHK  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic signed [31:0] origin_reg [3];
    logic [31:0]        inv_reg [3];
    logic signed [31:0] point_reg [3];
    logic [1:0]         axis_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        prod_next;
    logic               neg_reg;
    logic               neg_next;
    vts_pkg::entry_t    ent_reg;

    logic signed [32:0] diff;
    logic [32:0]        mag_full;
    logic [31:0]        whole;
    logic [31:0]        lim;
    logic               axis_hit;
    logic signed [vts_pkg::FRAC_W-1:0] frac;

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == F_IDLE);
    assign push       = (state_reg == F_PUSH) && !q_stat.full;
    assign push_entry = ent_reg;

    // Offset from the origin and its magnitude times the inverse spacing.
    always_comb
    begin
        diff      = {point_reg[axis_reg][31], point_reg[axis_reg]}
                  - {origin_reg[axis_reg][31], origin_reg[axis_reg]};
        neg_next  = diff[32];
        mag_full  = neg_next ? 33'(-diff) : 33'(diff);
        prod_next = mag_full[31:0] * inv_reg[axis_reg];
    end

    // Cell index and fraction check on the registered product.
    always_comb
    begin
        whole = prod_reg[63:32];
        unique case (axis_reg)
            2'd0:    lim = LIM_X;
            2'd1:    lim = LIM_Y;
            default: lim = LIM_Z;
        endcase
        axis_hit = neg_reg ? (whole == 32'd0) : (whole <= lim);
        frac     = neg_reg ? -$signed({1'b0, prod_reg[31:16]})
                           : $signed({1'b0, prod_reg[31:16]});
    end

    // State sequencing.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = item.opcode ? F_MUL : F_PUSH;
                end
            end
            F_MUL:   state_next = F_CHK;
            F_CHK:   state_next = (axis_reg == 2'd2) ? F_PUSH : F_MUL;
            F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            axis_reg      <= 2'd0;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            inv_reg[0]    <= vts_pkg::INV_RESET;
            inv_reg[1]    <= vts_pkg::INV_RESET;
            inv_reg[2]    <= vts_pkg::INV_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    vts_pkg::REG_ORIGIN_X: origin_reg[0] <= cfg.data;
                    vts_pkg::REG_ORIGIN_Y: origin_reg[1] <= cfg.data;
                    vts_pkg::REG_ORIGIN_Z: origin_reg[2] <= cfg.data;
                    vts_pkg::REG_INV_X:    inv_reg[0]    <= cfg.data;
                    vts_pkg::REG_INV_Y:    inv_reg[1]    <= cfg.data;
                    vts_pkg::REG_INV_Z:    inv_reg[2]    <= cfg.data;
                    default:               ;
                endcase
            end
            if (state_reg == F_IDLE)
            begin
                axis_reg <= 2'd0;
            end
            else if (state_reg == F_CHK)
            begin
                axis_reg <= axis_reg + 2'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            point_reg[0]  <= item.point_x;
            point_reg[1]  <= item.point_y;
            point_reg[2]  <= item.point_z;
            ent_reg.is_load <= !item.opcode;
            ent_reg.hit     <= 1'b1;
            ent_reg.voxel   <= item.voxel_value;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
        if (state_reg == F_CHK)
        begin
            ent_reg.hit <= ent_reg.hit && axis_hit;
            unique case (axis_reg)
                2'd0:
                begin
                    ent_reg.ix <= whole[vts_pkg::IDX_W-1:0];
                    ent_reg.fx <= frac;
                end
                2'd1:
                begin
                    ent_reg.iy <= whole[vts_pkg::IDX_W-1:0];
                    ent_reg.fy <= frac;
                end
                default:
                begin
                    ent_reg.iz <= whole[vts_pkg::IDX_W-1:0];
                    ent_reg.fz <= frac;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/vts_queue.sv]
// Short queue of classified words between the front and the back.
`default_nettype none
module vts_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  vts_pkg::entry_t         push_entry,
    input  wire logic               pop,
    output vts_pkg::entry_t         head,
    output vts_pkg::q_stat_t        q_stat
);

    localparam int PTR_W = $clog2(vts_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(vts_pkg::Q_DEPTH + 1);

    vts_pkg::entry_t   mem_reg [vts_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign head         = mem_reg[rd_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CNT_W'(vts_pkg::Q_DEPTH));

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(vts_pkg::Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(vts_pkg::Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

[rtl/vts_back.sv]
// Back end: voxel store, corner reads and the trilinear blend pipeline.
`default_nettype none
module vts_back #(
    parameter int DIM_X = vts_pkg::DIM_X_DEF,
    parameter int DIM_Y = vts_pkg::DIM_Y_DEF,
    parameter int DIM_Z = vts_pkg::DIM_Z_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  vts_pkg::entry_t   head,
    input  vts_pkg::q_stat_t  q_stat,
    output logic              pop,
    vts_result_if.source      result
);

    localparam int unsigned DXY    = DIM_X * DIM_Y;
    localparam int unsigned COUNT  = DIM_X * DIM_Y * DIM_Z;
    localparam int          ADDR_W = $clog2(COUNT);
    localparam int unsigned LOAD_LIMIT = (COUNT < (1 << vts_pkg::LOAD_W)) ? COUNT
                                       : (1 << vts_pkg::LOAD_W);
    localparam int WW = vts_pkg::WGT_W;

    logic                        busy_reg;
    logic                        issue_reg;
    logic [2:0]                  rdk_reg;
    logic [vts_pkg::LOAD_W-1:0]  load_pos_reg;
    logic                        out_valid_reg;
    logic signed [vts_pkg::OUT_W-1:0] out_value_reg;
    logic                        out_hit_reg;

    logic [vts_pkg::IDX_W-1:0]   ix_reg, iy_reg, iz_reg;
    logic signed [WW-1:0]        wx0_reg, wx1_reg, wy0_reg, wy1_reg, wz0_reg, wz1_reg;

    logic                        rv_reg, pv_reg, axv_reg, pyv_reg, ayv_reg, pzv_reg, azv_reg;
    logic [2:0]                  rtag_reg, ptag_reg, axtag_reg, pytag_reg, aytag_reg, pztag_reg;
    logic signed [34:0]          px_reg, ax_hold_reg;
    logic signed [35:0]          ax_sum_reg;
    logic signed [53:0]          py_reg, ay_hold_reg;
    logic signed [54:0]          ay_sum_reg;
    logic signed [56:0]          pz_reg, az_hold_reg;
    logic signed [57:0]          az_sum_reg;

    logic                        start_q, miss_q, do_load, fire;
    logic [vts_pkg::VOX_W-1:0]   rdata;
    logic [ADDR_W-1:0]           ram_addr;
    logic [31:0]                 rd_addr32;
    logic [vts_pkg::LOAD_W:0]    load_inc;
    logic signed [38:0]          ay_q;

    assign fire    = result.valid && result.ready;
    assign do_load = !q_stat.empty && !busy_reg && head.is_load;
    assign start_q = !q_stat.empty && !busy_reg && !head.is_load && head.hit && !out_valid_reg;
    assign miss_q  = !q_stat.empty && !busy_reg && !head.is_load && !head.hit && !out_valid_reg;
    assign pop     = do_load || start_q || miss_q;

    assign result.valid         = out_valid_reg;
    assign result.sampled_value = out_value_reg;
    assign result.inside_grid   = out_hit_reg;

    // Corner address for the current read step: bit 0 x, bit 1 y, bit 2 z.
    assign rd_addr32 = (32'(iz_reg) + 32'(rdk_reg[2])) * DXY
                     + (32'(iy_reg) + 32'(rdk_reg[1])) * 32'(DIM_X)
                     + 32'(ix_reg) + 32'(rdk_reg[0]);
    assign ram_addr  = do_load ? ADDR_W'(load_pos_reg) : ADDR_W'(rd_addr32);
    assign load_inc  = {1'b0, load_pos_reg} + 1'b1;

    vts_ram #(
        .WIDTH (vts_pkg::VOX_W),
        .DEPTH (COUNT)
    ) u_store (
        .clk   (clk),
        .we    (do_load),
        .addr  (ram_addr),
        .wdata (head.voxel),
        .rdata (rdata)
    );

    // Floor shift of the y blend.
    assign ay_q = $signed(ay_sum_reg[54:16]);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_reg     <= 1'b0;
            rdk_reg       <= 3'd0;
            load_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            axv_reg       <= 1'b0;
            pyv_reg       <= 1'b0;
            ayv_reg       <= 1'b0;
            pzv_reg       <= 1'b0;
            azv_reg       <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                load_pos_reg <= (load_inc >= (vts_pkg::LOAD_W + 1)'(LOAD_LIMIT)) ? '0
                              : load_inc[vts_pkg::LOAD_W-1:0];
            end
            if (start_q)
            begin
                busy_reg  <= 1'b1;
                issue_reg <= 1'b1;
                rdk_reg   <= 3'd0;
            end
            else if (issue_reg)
            begin
                rdk_reg <= rdk_reg + 3'd1;
                if (rdk_reg == 3'd7)
                begin
                    issue_reg <= 1'b0;
                end
            end
            rv_reg  <= issue_reg;
            pv_reg  <= rv_reg;
            axv_reg <= pv_reg && ptag_reg[0];
            pyv_reg <= axv_reg;
            ayv_reg <= pyv_reg && pytag_reg[1];
            pzv_reg <= ayv_reg;
            azv_reg <= pzv_reg && pztag_reg[2];
            if (azv_reg)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (miss_q)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Blend datapath: each multiply and each add is followed by a register.
    always_ff @(posedge clk)
    begin
        if (start_q)
        begin
            ix_reg  <= head.ix;
            iy_reg  <= head.iy;
            iz_reg  <= head.iz;
            wx0_reg <= WW'(32'sd65536) - WW'(head.fx);
            wx1_reg <= WW'(head.fx);
            wy0_reg <= WW'(32'sd65536) - WW'(head.fy);
            wy1_reg <= WW'(head.fy);
            wz0_reg <= WW'(32'sd65536) - WW'(head.fz);
            wz1_reg <= WW'(head.fz);
        end
        rtag_reg  <= rdk_reg;
        ptag_reg  <= rtag_reg;
        px_reg    <= $signed({1'b0, rdata}) * (rtag_reg[0] ? wx1_reg : wx0_reg);
        axtag_reg <= ptag_reg;
        if (pv_reg)
        begin
            if (ptag_reg[0])
            begin
                ax_sum_reg <= 36'(ax_hold_reg) + 36'(px_reg);
            end
            else
            begin
                ax_hold_reg <= px_reg;
            end
        end
        pytag_reg <= axtag_reg;
        py_reg    <= ax_sum_reg * (axtag_reg[1] ? wy1_reg : wy0_reg);
        aytag_reg <= pytag_reg;
        if (pyv_reg)
        begin
            if (pytag_reg[1])
            begin
                ay_sum_reg <= 55'(ay_hold_reg) + 55'(py_reg);
            end
            else
            begin
                ay_hold_reg <= py_reg;
            end
        end
        pztag_reg <= aytag_reg;
        pz_reg    <= ay_q * (aytag_reg[2] ? wz1_reg : wz0_reg);
        if (pzv_reg)
        begin
            if (pztag_reg[2])
            begin
                az_sum_reg <= 58'(az_hold_reg) + 58'(pz_reg);
            end
            else
            begin
                az_hold_reg <= pz_reg;
            end
        end
        if (azv_reg)
        begin
            out_value_reg <= $signed(az_sum_reg[55:16]);
            out_hit_reg   <= 1'b1;
        end
        else if (miss_q)
        begin
            out_value_reg <= '0;
            out_hit_reg   <= 1'b0;
        end
    end

    // Checks on the sequencing.
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> busy_reg)
        else $error("corner reads issued outside a query");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop)
        else $error("queue popped while a query is in flight");
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        azv_reg |-> !out_valid_reg && busy_reg)
        else $error("blend finished while the output register was occupied");
    a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
        32'(load_pos_reg) < LOAD_LIMIT)
        else $error("load position out of range");

endmodule
`default_nettype wire
